/* design/hsl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_pkg: shared types and constants for the hash sequence LCS similarity
// Widths, request codes, popcount masks and the command passed through the
// command queue between the front end and the compute back end.
// ----------------------------------------------------------------------------
package hsl_pkg;

  localparam int MaxLen     = 256;
  localparam int LenW       = $clog2(MaxLen + 1);
  localparam int AddrW      = $clog2(MaxLen);
  localparam int HashW      = 64;
  localparam int ThrW       = 7;
  localparam int FracW      = 16;
  localparam int RatioW     = FracW + 1;
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  localparam logic [ThrW-1:0] ThrReset = ThrW'(21);

  localparam logic [1:0] ReqLoadA   = 2'd0;
  localparam logic [1:0] ReqLoadB   = 2'd1;
  localparam logic [1:0] ReqCompute = 2'd2;

  localparam logic [HashW-1:0] PopM1 = 64'h5555555555555555;
  localparam logic [HashW-1:0] PopM2 = 64'h3333333333333333;
  localparam logic [HashW-1:0] PopM4 = 64'h0f0f0f0f0f0f0f0f;

  typedef enum logic [1:0] {
    KindLoadA   = 2'd0,
    KindLoadB   = 2'd1,
    KindCompute = 2'd2
  } req_kind_e;

  typedef struct packed {
    req_kind_e        kind;
    logic [HashW-1:0] hash;
  } cmd_t;

endpackage

/* design/hsl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_front: request intake
// Accepts request transactions, decodes the request type and pushes valid
// commands into the command queue. Unknown request types are dropped.
// ----------------------------------------------------------------------------
module hsl_front import hsl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       req_type_i,
  input  logic [HashW-1:0] hash_value_i,
  input  logic             full_i,
  output logic             push_o,
  output cmd_t             push_cmd_o
);

  logic      known;
  req_kind_e kind;

  always_comb begin
    known = 1'b1;
    kind  = KindLoadA;
    unique case (req_type_i)
      ReqLoadA:   kind = KindLoadA;
      ReqLoadB:   kind = KindLoadB;
      ReqCompute: kind = KindCompute;
      default:    known = 1'b0;
    endcase
  end

  assign busy_o          = full_i;
  assign push_o          = start_i && !full_i && known;
  assign push_cmd_o.kind = kind;
  assign push_cmd_o.hash = hash_value_i;

endmodule

/* design/hsl_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_queue: command queue
// A short FIFO of commands that decouples request intake from the compute
// back end.
// ----------------------------------------------------------------------------
module hsl_queue import hsl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t push_cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q;
  logic [QPtrW-1:0] rd_ptr_q;
  logic [QCntW-1:0] cnt_q;
  logic [QCntW-1:0] cnt_d;

  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCntW'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

/* design/hsl_divider.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_divider: ratio divider
// Restoring divider that forms floor(dividend * 2^16 / divisor) one quotient
// bit per cycle, for a dividend that does not exceed the divisor.
// ----------------------------------------------------------------------------
module hsl_divider import hsl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [LenW-1:0]   dividend_i,
  input  logic [LenW-1:0]   divisor_i,
  output logic              done_o,
  output logic [RatioW-1:0] quotient_o
);

  localparam int BitW = $clog2(FracW + 1);

  logic              busy_q;
  logic              done_q;
  logic [BitW-1:0]   bit_q;
  logic [LenW:0]     rem_q;
  logic [LenW-1:0]   div_q;
  logic [RatioW-1:0] quo_q;
  logic              ge;
  logic [LenW:0]     rem_next;

  assign ge       = (rem_q >= {1'b0, div_q});
  assign rem_next = ge ? (rem_q - {1'b0, div_q}) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      bit_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        bit_q  <= BitW'(FracW);
      end else if (busy_q) begin
        if (bit_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          bit_q <= bit_q - BitW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, dividend_i};
      div_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= {rem_next[LenW-1:0], 1'b0};
      quo_q <= {quo_q[RatioW-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* design/hsl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_back: sequence stores and LCS engine
// Executes queued commands: appends hashes to the two sequence stores and,
// on a compute command, sweeps the LCS row one cell per cycle through a
// three-stage pipeline, then divides for the match ratio.
// ----------------------------------------------------------------------------
module hsl_back import hsl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic [ThrW-1:0]   cfg_data_i,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_pop_o,
  output logic              done_o,
  output logic [LenW-1:0]   lcs_length_o,
  output logic [LenW-1:0]   shorter_length_o,
  output logic [RatioW-1:0] match_ratio_o,
  output logic              empty_error_o,
  output logic              overflowed_o
);

  typedef enum logic [3:0] {
    StIdle     = 4'b0001,
    StRowStart = 4'b0010,
    StRowRun   = 4'b0100,
    StDivide   = 4'b1000
  } state_e;

  function automatic logic [ThrW-1:0] popcount64(input logic [HashW-1:0] x);
    logic [HashW-1:0] s1;
    logic [HashW-1:0] s2;
    logic [HashW-1:0] s4;
    logic [ThrW-1:0]  acc;
    s1  = x - ((x >> 1) & PopM1);
    s2  = (s1 & PopM2) + ((s1 >> 2) & PopM2);
    s4  = (s2 + (s2 >> 4)) & PopM4;
    acc = '0;
    for (int b = 0; b < 8; b++) begin
      acc = acc + ThrW'(s4[b*8 +: 4]);
    end
    return acc;
  endfunction

  state_e           state_q;
  state_e           state_d;
  logic [ThrW-1:0]  thr_q;
  logic [LenW-1:0]  cnt_a_q;
  logic [LenW-1:0]  cnt_b_q;
  logic             ovf_q;
  logic [AddrW-1:0] i_q;
  logic [AddrW-1:0] k_q;
  logic             issuing_q;
  logic             p1_valid_q;
  logic             p2_valid_q;
  logic [AddrW-1:0] k_p1_q;
  logic [AddrW-1:0] k_p2_q;
  logic             done_q;

  logic [HashW-1:0] seq_a_mem [MaxLen];
  logic [HashW-1:0] seq_b_mem [MaxLen];
  logic [LenW-1:0]  dp_mem    [MaxLen];
  logic [HashW-1:0] a_rd_q;
  logic [HashW-1:0] b_rd_q;
  logic [LenW-1:0]  above_rd_q;

  logic             match_q;
  logic [LenW-1:0]  above_q;
  logic [LenW-1:0]  left_q;
  logic [LenW-1:0]  diag_q;
  logic [LenW-1:0]  new_val;

  logic [LenW-1:0]   lcs_q;
  logic [LenW-1:0]   shorter_q;
  logic [RatioW-1:0] ratio_q;
  logic              err_q;
  logic              ovf_out_q;

  logic              is_load_a;
  logic              is_load_b;
  logic              is_compute;
  logic              full_a;
  logic              full_b;
  logic              empty;
  logic [LenW-1:0]   shorter;
  logic [LenW-1:0]   cnt_a_m1;
  logic [LenW-1:0]   cnt_b_m1;
  logic              last_k;
  logic              last_row;
  logic              issue;
  logic              row_done;
  logic              wr_a;
  logic              wr_b;
  logic              div_start;
  logic              div_done;
  logic [RatioW-1:0] div_quo;

  assign is_load_a  = cmd_valid_i && (cmd_i.kind == KindLoadA);
  assign is_load_b  = cmd_valid_i && (cmd_i.kind == KindLoadB);
  assign is_compute = cmd_valid_i && (cmd_i.kind == KindCompute);
  assign full_a     = (cnt_a_q == LenW'(MaxLen));
  assign full_b     = (cnt_b_q == LenW'(MaxLen));
  assign empty      = (cnt_a_q == '0) || (cnt_b_q == '0);
  assign shorter    = (cnt_a_q <= cnt_b_q) ? cnt_a_q : cnt_b_q;
  assign cnt_a_m1   = cnt_a_q - LenW'(1);
  assign cnt_b_m1   = cnt_b_q - LenW'(1);
  assign last_k     = (k_q == cnt_b_m1[AddrW-1:0]);
  assign last_row   = (i_q == cnt_a_m1[AddrW-1:0]);
  assign issue      = (state_q == StRowRun) && issuing_q;
  assign row_done   = (state_q == StRowRun) && !issuing_q && !p1_valid_q && !p2_valid_q;
  assign wr_a       = (state_q == StIdle) && is_load_a && !full_a;
  assign wr_b       = (state_q == StIdle) && is_load_b && !full_b;
  assign new_val    = match_q ? (diag_q + LenW'(1))
                              : ((left_q > above_q) ? left_q : above_q);

  always_comb begin
    state_d   = state_q;
    cmd_pop_o = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          if (is_compute && !empty) begin
            state_d = StRowStart;
          end
        end
      end
      StRowStart: begin
        state_d = StRowRun;
      end
      StRowRun: begin
        if (row_done) begin
          if (last_row) begin
            div_start = 1'b1;
            state_d   = StDivide;
          end else begin
            state_d = StRowStart;
          end
        end
      end
      StDivide: begin
        if (div_done) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      thr_q      <= ThrReset;
      cnt_a_q    <= '0;
      cnt_b_q    <= '0;
      ovf_q      <= 1'b0;
      i_q        <= '0;
      k_q        <= '0;
      issuing_q  <= 1'b0;
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      done_q     <= 1'b0;
      p1_valid_q <= issue;
      p2_valid_q <= p1_valid_q;
      if (cfg_valid_i) begin
        thr_q <= cfg_data_i;
      end
      unique case (state_q)
        StIdle: begin
          if (is_load_a) begin
            if (full_a) begin
              ovf_q <= 1'b1;
            end else begin
              cnt_a_q <= cnt_a_q + LenW'(1);
            end
          end
          if (is_load_b) begin
            if (full_b) begin
              ovf_q <= 1'b1;
            end else begin
              cnt_b_q <= cnt_b_q + LenW'(1);
            end
          end
          if (is_compute) begin
            i_q <= '0;
            if (empty) begin
              done_q  <= 1'b1;
              cnt_a_q <= '0;
              cnt_b_q <= '0;
              ovf_q   <= 1'b0;
            end
          end
        end
        StRowStart: begin
          k_q       <= '0;
          issuing_q <= 1'b1;
        end
        StRowRun: begin
          if (issue) begin
            if (last_k) begin
              issuing_q <= 1'b0;
            end else begin
              k_q <= k_q + AddrW'(1);
            end
          end
          if (row_done && !last_row) begin
            i_q <= i_q + AddrW'(1);
          end
        end
        StDivide: begin
          if (div_done) begin
            done_q  <= 1'b1;
            cnt_a_q <= '0;
            cnt_b_q <= '0;
            ovf_q   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      seq_a_mem[cnt_a_q[AddrW-1:0]] <= cmd_i.hash;
    end
    if (state_q == StRowStart) begin
      a_rd_q <= seq_a_mem[i_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      seq_b_mem[cnt_b_q[AddrW-1:0]] <= cmd_i.hash;
    end
    if (issue) begin
      b_rd_q <= seq_b_mem[k_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_valid_q) begin
      dp_mem[k_p2_q] <= new_val;
    end
    if (issue) begin
      above_rd_q <= dp_mem[k_q];
    end
  end

  always_ff @(posedge clk_i) begin
    k_p1_q <= k_q;
    k_p2_q <= k_p1_q;
    if (p1_valid_q) begin
      match_q <= (popcount64(a_rd_q ^ b_rd_q) <= thr_q);
      above_q <= (i_q == '0) ? '0 : above_rd_q;
    end
    if (state_q == StRowStart) begin
      left_q <= '0;
      diag_q <= '0;
    end else if (p2_valid_q) begin
      left_q <= new_val;
      diag_q <= above_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == StIdle) && is_compute && empty) begin
      lcs_q     <= '0;
      shorter_q <= '0;
      ratio_q   <= '0;
      err_q     <= 1'b1;
      ovf_out_q <= ovf_q;
    end else if ((state_q == StDivide) && div_done) begin
      lcs_q     <= left_q;
      shorter_q <= shorter;
      ratio_q   <= div_quo;
      err_q     <= 1'b0;
      ovf_out_q <= ovf_q;
    end
  end

  hsl_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (left_q),
    .divisor_i  (shorter),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign done_o           = done_q;
  assign lcs_length_o     = lcs_q;
  assign shorter_length_o = shorter_q;
  assign match_ratio_o    = ratio_q;
  assign empty_error_o    = err_q;
  assign overflowed_o     = ovf_out_q;

endmodule

/* design/hash_sequence_lcs_similarity.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_sequence_lcs_similarity: LCS similarity of two hash sequences
// Loads two sequences of 64-bit hashes and, on a compute request, reports the
// thresholded LCS length, the shorter length and their Q1.16 ratio.
// ----------------------------------------------------------------------------
// Channel   Handshake                Payload
// request   start / busy             req_type_i, hash_value_i
// config    cfg_valid_i/cfg_ready_o  cfg_data_i (match threshold)
// result    done_o strobe, 1 cycle   lcs_length_o, shorter_length_o,
//                                    match_ratio_o, empty_error_o, overflowed_o
//
// A compute runs the one-cell-per-cycle LCS row sweep over the row memory,
// then the divide; a compute on an empty sequence skips both and sets
// empty_error_o. A two-entry command queue lets requests be taken while a
// compute runs; busy is high only while that queue is full. Reset clears
// counts and the overflow flag and sets the threshold to 21; the stores need
// no clearing. Results cannot be stalled.
// ----------------------------------------------------------------------------
module hash_sequence_lcs_similarity import hsl_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        req_type_i,
  input  logic [HashW-1:0]  hash_value_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [ThrW-1:0]   cfg_data_i,
  output logic              done_o,
  output logic [LenW-1:0]   lcs_length_o,
  output logic [LenW-1:0]   shorter_length_o,
  output logic [RatioW-1:0] match_ratio_o,
  output logic              empty_error_o,
  output logic              overflowed_o
);

  logic push;
  cmd_t push_cmd;
  logic full;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  assign cfg_ready_o = 1'b1;

  hsl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .req_type_i   (req_type_i),
    .hash_value_i (hash_value_i),
    .full_i       (full),
    .push_o       (push),
    .push_cmd_o   (push_cmd)
  );

  hsl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (cmd_pop),
    .valid_o    (cmd_valid),
    .cmd_o      (cmd)
  );

  hsl_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .cmd_valid_i      (cmd_valid),
    .cmd_i            (cmd),
    .cmd_pop_o        (cmd_pop),
    .done_o           (done_o),
    .lcs_length_o     (lcs_length_o),
    .shorter_length_o (shorter_length_o),
    .match_ratio_o    (match_ratio_o),
    .empty_error_o    (empty_error_o),
    .overflowed_o     (overflowed_o)
  );

endmodule
